// ----- sv/agv_pkg.sv -----
// Package for the audio gain, gate and voice activity detector.
// Holds payload and config structs, register indexes, FSM states and constants.
// No dependencies.
package agv_pkg;

	localparam int MAX_CHUNK     = 1024;
	localparam int LEVEL_HISTORY = 10;
	localparam int GATE_LIMIT    = 328;
	localparam int DIV_STEPS     = 41;
	localparam int SQRT_STEPS    = 16;

	typedef enum logic [1:0] {
		OP_SAMPLE = 2'd0,
		OP_TICK   = 2'd1,
		OP_START  = 2'd2,
		OP_END    = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		EV_NONE  = 2'd0,
		EV_START = 2'd1,
		EV_END   = 2'd2
	} ev_t;

	typedef enum logic [1:0] {
		REG_GAIN      = 2'd0,
		REG_THRESHOLD = 2'd1,
		REG_GATE      = 2'd2,
		REG_HANGOVER  = 2'd3
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_ACC,
		ST_DIV,
		ST_SQRT_LOAD,
		ST_SQRT,
		ST_RING,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic [1:0]         operation;
		logic signed [15:0] sample_in;
		logic               last_in_chunk;
	} item_t;

	typedef struct packed {
		logic signed [15:0] processed_sample;
		logic               chunk_done;
		logic [15:0]        rms_val;
		logic [14:0]        peak_mag;
		logic               voice_on;
		logic [1:0]         event_code;
		logic [15:0]        segment_count;
		logic [31:0]        duration_ms;
	} result_t;

	typedef struct packed {
		logic [9:0]  gain_q8;
		logic [15:0] voice_thresh;
		logic        noise_gate_enable;
		logic [15:0] hangover_ticks;
	} cfg_t;

	typedef struct packed {
		logic load_in;
		logic exec;
		logic acc;
		logic div_step;
		logic sqrt_load;
		logic sqrt_step;
		logic ring;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic is_sample;
		logic chunk_end;
		logic div_last;
		logic sqrt_last;
		logic out_free;
	} status_t;

endpackage

// ----- sv/agv_ctrl.sv -----
// Controller FSM for the voice activity detector.
// Sequences decode, accumulate, divide, square root, ring update and output.
// Depends on agv_pkg.
module agv_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_ready,
	input  agv_pkg::status_t status,
	output agv_pkg::cmd_t    cmd
);

	agv_pkg::state_t state_q, state_d;

	// hold state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= agv_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			agv_pkg::ST_IDLE: begin
				if (item_valid) state_d = agv_pkg::ST_EXEC;
			end
			agv_pkg::ST_EXEC: begin
				state_d = status.is_sample ? agv_pkg::ST_ACC : agv_pkg::ST_FINISH;
			end
			agv_pkg::ST_ACC: begin
				state_d = status.chunk_end ? agv_pkg::ST_DIV : agv_pkg::ST_FINISH;
			end
			agv_pkg::ST_DIV: begin
				if (status.div_last) state_d = agv_pkg::ST_SQRT_LOAD;
			end
			agv_pkg::ST_SQRT_LOAD: begin
				state_d = agv_pkg::ST_SQRT;
			end
			agv_pkg::ST_SQRT: begin
				if (status.sqrt_last) state_d = agv_pkg::ST_RING;
			end
			agv_pkg::ST_RING: begin
				state_d = agv_pkg::ST_FINISH;
			end
			agv_pkg::ST_FINISH: begin
				if (status.out_free) state_d = agv_pkg::ST_IDLE;
			end
			default: begin
				state_d = agv_pkg::ST_IDLE;
			end
		endcase
	end

	// drive commands
	always_comb begin
		cmd        = '0;
		item_ready = 1'b0;
		case (state_q)
			agv_pkg::ST_IDLE: begin
				item_ready  = 1'b1;
				cmd.load_in = item_valid;
			end
			agv_pkg::ST_EXEC:      cmd.exec      = 1'b1;
			agv_pkg::ST_ACC:       cmd.acc       = 1'b1;
			agv_pkg::ST_DIV:       cmd.div_step  = 1'b1;
			agv_pkg::ST_SQRT_LOAD: cmd.sqrt_load = 1'b1;
			agv_pkg::ST_SQRT:      cmd.sqrt_step = 1'b1;
			agv_pkg::ST_RING:      cmd.ring      = 1'b1;
			agv_pkg::ST_FINISH:    cmd.load_out  = status.out_free;
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

// ----- sv/agv_dp.sv -----
// Datapath for the voice activity detector: gain and gate, chunk
// accumulation, bit-serial divider and square root, level ring, voice state.
// Depends on agv_pkg.
module agv_dp (
	input  logic             clk,
	input  logic             arst_n,
	input  agv_pkg::cmd_t    cmd,
	output agv_pkg::status_t status,
	input  agv_pkg::cfg_t    cfg,
	input  agv_pkg::item_t   item,
	output logic             result_valid,
	input  logic             result_ready,
	output agv_pkg::result_t result
);

	agv_pkg::item_t     in_q;
	logic signed [15:0] proc_q;
	logic               done_q;
	logic [15:0]        rms_q;
	logic [14:0]        peak_out_q;
	logic [1:0]         ev_q;

	logic [40:0] sum_q;
	logic [10:0] count_q;
	logic [14:0] peak_q;

	logic [40:0] dvd_q;
	logic [10:0] dvs_q;
	logic [10:0] rem_q;
	logic [5:0]  cnt_q;
	logic [30:0] sv_q;
	logic [31:0] sres_q;
	logic [31:0] sbit_q;

	logic [15:0] ring_q [agv_pkg::LEVEL_HISTORY];
	logic [3:0]  pos_q;
	logic [19:0] total_q;

	logic        voice_q;
	logic [15:0] hang_q;
	logic        hang_run_q;
	logic [31:0] time_q;
	logic [31:0] vstart_q;
	logic [31:0] sstart_q;
	logic [15:0] seg_q;
	logic        out_valid_q;

	// gain, truncate toward zero, saturate, gate
	logic signed [26:0] prod;
	logic signed [26:0] prod_adj;
	logic signed [18:0] qv;
	logic signed [15:0] gained;
	always_comb begin
		prod     = 27'(in_q.sample_in) * $signed({17'd0, cfg.gain_q8});
		prod_adj = prod + (prod[26] ? 27'sd255 : 27'sd0);
		qv       = 19'(prod_adj >>> 8);
		if (qv > 19'sd32767) gained = 16'sd32767;
		else if (qv < -19'sd32768) gained = -16'sd32768;
		else gained = qv[15:0];
		if (cfg.noise_gate_enable && gained > -16'(agv_pkg::GATE_LIMIT) &&
		    gained < 16'(agv_pkg::GATE_LIMIT)) gained = 16'sd0;
	end

	// magnitude and square of the processed sample
	logic [15:0] mag_raw;
	logic [14:0] mag;
	logic [31:0] sq;
	logic [14:0] peak_new;
	logic [40:0] sum_new;
	logic [11:0] count_new;
	always_comb begin
		mag_raw   = proc_q[15] ? 16'(-proc_q) : 16'(proc_q);
		mag       = mag_raw[15] ? 15'h7FFF : mag_raw[14:0];
		sq        = 32'(proc_q) * 32'(proc_q);
		peak_new  = (mag > peak_q) ? mag : peak_q;
		sum_new   = sum_q + 41'(sq);
		count_new = {1'b0, count_q} + 12'd1;
	end

	// one divider step
	logic [11:0] dshift;
	logic        dfit;
	assign dshift = {rem_q, dvd_q[40]};
	assign dfit   = dshift >= {1'b0, dvs_q};

	// one square root step
	logic [31:0] strial;
	logic        sfit;
	assign strial = sres_q + sbit_q;
	assign sfit   = {1'b0, sv_q} >= strial;

	// ring update and detection
	logic [15:0] rms_new;
	logic [19:0] total_new;
	logic        detect;
	always_comb begin
		rms_new   = sres_q[15:0];
		total_new = total_q - 20'(ring_q[pos_q]) + 20'(rms_new);
		detect    = (rms_new > cfg.voice_thresh) &&
		            (24'(rms_new) * 24'(2 * agv_pkg::LEVEL_HISTORY) > 24'(total_new) * 24'd3);
	end

	logic [31:0] time_inc;
	assign time_inc = time_q + 32'd1;

	assign status.is_sample = in_q.operation == agv_pkg::OP_SAMPLE;
	assign status.chunk_end = in_q.last_in_chunk || (count_new >= 12'(agv_pkg::MAX_CHUNK));
	assign status.div_last  = cnt_q == 6'(agv_pkg::DIV_STEPS - 1);
	assign status.sqrt_last = cnt_q == 6'(agv_pkg::SQRT_STEPS - 1);
	assign status.out_free  = !out_valid_q || result_ready;

	// capture the request and per-item result fields
	always_ff @(posedge clk) begin
		if (cmd.load_in) in_q <= item;
		if (cmd.exec) begin
			proc_q     <= status.is_sample ? gained : 16'sd0;
			done_q     <= 1'b0;
			rms_q      <= 16'd0;
			peak_out_q <= 15'd0;
		end
		if (cmd.acc && status.chunk_end) begin
			peak_out_q <= peak_new;
			done_q     <= 1'b1;
			dvd_q      <= sum_new;
			dvs_q      <= count_new[10:0];
			rem_q      <= 11'd0;
		end
		if (cmd.div_step) begin
			rem_q <= dfit ? 11'(dshift - {1'b0, dvs_q}) : dshift[10:0];
			dvd_q <= {dvd_q[39:0], dfit};
		end
		if (cmd.sqrt_load) begin
			sv_q   <= dvd_q[30:0];
			sres_q <= 32'd0;
			sbit_q <= 32'd1 << 30;
		end
		if (cmd.sqrt_step) begin
			if (sfit) begin
				sv_q   <= sv_q - strial[30:0];
				sres_q <= (sres_q >> 1) + sbit_q;
			end else begin
				sres_q <= sres_q >> 1;
			end
			sbit_q <= sbit_q >> 2;
		end
		if (cmd.ring) rms_q <= rms_new;
	end

	// advance the step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if ((cmd.acc && status.chunk_end) || cmd.sqrt_load) begin
			cnt_q <= '0;
		end else if (cmd.div_step || cmd.sqrt_step) begin
			cnt_q <= cnt_q + 6'd1;
		end
	end

	// chunk accumulators, ring and voice state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q      <= '0;
			count_q    <= '0;
			peak_q     <= '0;
			ring_q     <= '{default: '0};
			pos_q      <= '0;
			total_q    <= '0;
			voice_q    <= 1'b0;
			hang_q     <= '0;
			hang_run_q <= 1'b0;
			time_q     <= '0;
			vstart_q   <= '0;
			sstart_q   <= '0;
			seg_q      <= '0;
			ev_q       <= agv_pkg::EV_NONE;
		end else begin
			if (cmd.exec) begin
				ev_q <= agv_pkg::EV_NONE;
				case (in_q.operation)
					agv_pkg::OP_TICK: begin
						time_q <= time_inc;
						if (hang_run_q) begin
							if (hang_q <= 16'd1) begin
								hang_q     <= '0;
								hang_run_q <= 1'b0;
								if (voice_q) begin
									voice_q  <= 1'b0;
									sstart_q <= time_inc;
									ev_q     <= agv_pkg::EV_END;
								end
							end else begin
								hang_q <= hang_q - 16'd1;
							end
						end
					end
					agv_pkg::OP_START: begin
						if (!voice_q) begin
							voice_q  <= 1'b1;
							vstart_q <= time_q;
							seg_q    <= seg_q + 16'd1;
							ev_q     <= agv_pkg::EV_START;
						end
					end
					agv_pkg::OP_END: begin
						if (voice_q) begin
							voice_q  <= 1'b0;
							sstart_q <= time_q;
							ev_q     <= agv_pkg::EV_END;
						end
					end
					default: begin
						ev_q <= agv_pkg::EV_NONE;
					end
				endcase
			end
			if (cmd.acc) begin
				if (status.chunk_end) begin
					sum_q   <= '0;
					count_q <= '0;
					peak_q  <= '0;
				end else begin
					sum_q   <= sum_new;
					count_q <= count_new[10:0];
					peak_q  <= peak_new;
				end
			end
			if (cmd.ring) begin
				ring_q[pos_q] <= rms_new;
				total_q       <= total_new;
				pos_q         <= (pos_q >= 4'(agv_pkg::LEVEL_HISTORY - 1)) ? 4'd0 : pos_q + 4'd1;
				if (detect && !voice_q) begin
					voice_q  <= 1'b1;
					vstart_q <= time_q;
					seg_q    <= seg_q + 16'd1;
					ev_q     <= agv_pkg::EV_START;
				end else if (!detect && voice_q) begin
					hang_q     <= cfg.hangover_ticks;
					hang_run_q <= 1'b1;
				end
			end
		end
	end

	// hold the result until the receiver takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (result_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			result.processed_sample <= proc_q;
			result.chunk_done       <= done_q;
			result.rms_val          <= rms_q;
			result.peak_mag         <= peak_out_q;
			result.voice_on         <= voice_q;
			result.event_code       <= ev_q;
			result.segment_count    <= seg_q;
			result.duration_ms      <= voice_q ? time_q - vstart_q : time_q - sstart_q;
		end
	end

	assign result_valid = out_valid_q;

endmodule

// ----- sv/audio_gain_gate_vad.sv -----
// Top level of the audio gain, gate and voice activity detector.
// Holds the APB register file and joins agv_ctrl with agv_dp.
// Depends on agv_pkg, agv_ctrl and agv_dp.
//
// Usage: requests enter on item (valid/ready), one result per request leaves
// on result (valid/ready). A request is a sample, a millisecond tick, a
// forced voice start or a forced voice end. The user must see that
// configuration is written over the APB port only while the block is idle;
// the block itself does not enforce this. pready is always high. The block
// handles one request at a time. A tick or force goes from accept through
// the exec and finish steps to result valid; a sample that does not end a
// chunk also passes the accumulate step. A sample that ends a chunk adds
// the bit-serial divider, the square root load and steps and the level ring.
// The next request is taken once the previous result sits in the output
// register, even if the receiver has not yet taken it; a stalled receiver
// holds the block in its finish step until the output register frees.
// Reset clears all chunk, ring and voice state and loads register defaults.
module audio_gain_gate_vad (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_ready,
	input  agv_pkg::item_t   item,
	output logic             result_valid,
	input  logic             result_ready,
	output agv_pkg::result_t result,
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [3:0]       paddr,
	input  logic [31:0]      pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	agv_pkg::cfg_t    cfg_q;
	agv_pkg::cmd_t    cmd;
	agv_pkg::status_t status;
	agv_pkg::reg_idx_t ridx;

	assign pready = 1'b1;
	assign ridx   = agv_pkg::reg_idx_t'(paddr[3:2]);

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain_q8           <= 10'd256;
			cfg_q.voice_thresh      <= 16'd655;
			cfg_q.noise_gate_enable <= 1'b0;
			cfg_q.hangover_ticks    <= 16'd500;
		end else if (psel && penable && pwrite) begin
			case (ridx)
				agv_pkg::REG_GAIN:      cfg_q.gain_q8           <= pwdata[9:0];
				agv_pkg::REG_THRESHOLD: cfg_q.voice_thresh      <= pwdata[15:0];
				agv_pkg::REG_GATE:      cfg_q.noise_gate_enable <= pwdata[0];
				agv_pkg::REG_HANGOVER:  cfg_q.hangover_ticks    <= pwdata[15:0];
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	// register reads
	always_comb begin
		case (ridx)
			agv_pkg::REG_GAIN:      prdata = {22'd0, cfg_q.gain_q8};
			agv_pkg::REG_THRESHOLD: prdata = {16'd0, cfg_q.voice_thresh};
			agv_pkg::REG_GATE:      prdata = {31'd0, cfg_q.noise_gate_enable};
			agv_pkg::REG_HANGOVER:  prdata = {16'd0, cfg_q.hangover_ticks};
			default:                prdata = 32'd0;
		endcase
	end

	agv_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.status     (status),
		.cmd        (cmd)
	);

	agv_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.cfg          (cfg_q),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

`ifndef SYNTHESIS
	a_metrics_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.chunk_done |->
		result.rms_val == 16'd0 && result.peak_mag == 15'd0)
		else $error("chunk metrics set without chunk end");
	a_start_active: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.event_code == agv_pkg::EV_START |-> result.voice_on)
		else $error("voice start event while inactive");
	a_end_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.event_code == agv_pkg::EV_END |-> !result.voice_on)
		else $error("voice end event while active");
	a_hold_out: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("stalled result changed");
`endif

endmodule

// ----- test/audio_gain_gate_vad_tb.sv -----
// Testbench for audio_gain_gate_vad: random and directed requests, a predictor
// of gain, gate, chunk RMS and voice state, and an in-order result check.
// Depends on agv_pkg and the RTL of audio_gain_gate_vad.
module audio_gain_gate_vad_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import agv_pkg::*;

	// Predicts VAD results and holds them until the block delivers
	class vad_scoreboard;
		logic [9:0]  gain;
		logic [15:0] thresh;
		logic        gate_on;
		logic [15:0] hang_ticks;
		logic [15:0] ring [LEVEL_HISTORY];
		int unsigned ring_pos;
		logic [19:0] ring_sum;
		logic [40:0] sq_sum;
		int unsigned n_samples;
		logic [14:0] peak_acc;
		bit          voice;
		logic [15:0] hang_cnt;
		bit          hang_run;
		logic [31:0] now_ms, voice_at, quiet_at;
		logic [15:0] seg_cnt;
		result_t     pending [$];
		int          errors;

		function new();
			gain = 256; thresh = 655; gate_on = 0; hang_ticks = 500;
			foreach (ring[i]) ring[i] = 0;
			ring_pos = 0; ring_sum = 0; sq_sum = 0; n_samples = 0; peak_acc = 0;
			voice = 0; hang_cnt = 0; hang_run = 0;
			now_ms = 0; voice_at = 0; quiet_at = 0; seg_cnt = 0; errors = 0;
		endfunction

		function void set_reg(reg_idx_t idx, logic [31:0] v);
			case (idx)
				REG_GAIN:      gain = v[9:0];
				REG_THRESHOLD: thresh = v[15:0];
				REG_GATE:      gate_on = v[0];
				REG_HANGOVER:  hang_ticks = v[15:0];
			endcase
		endfunction

		function logic [31:0] isqrt(logic [63:0] v);
			logic [63:0] r, b;
			r = 0;
			b = 64'd1 << 62;
			while (b > v) b >>= 2;
			while (b != 0) begin
				if (v >= r + b) begin
					v -= r + b;
					r = (r >> 1) + b;
				end else begin
					r >>= 1;
				end
				b >>= 2;
			end
			return r[31:0];
		endfunction

		function void start_seg(ref result_t r);
			voice = 1; voice_at = now_ms; seg_cnt++; r.event_code = EV_START;
		endfunction

		function void end_seg(ref result_t r);
			voice = 0; quiet_at = now_ms; r.event_code = EV_END;
		endfunction

		function void note_request(item_t it);
			result_t r;
			int p, q, mag;
			logic [31:0] rms;
			bit det;
			r = '0;
			case (op_t'(it.operation))
				OP_SAMPLE: begin
					p = int'(it.sample_in) * int'(gain);
					q = (p >= 0) ? p / 256 : -((-p) / 256);
					if (q > 32767) q = 32767;
					if (q < -32768) q = -32768;
					if (gate_on && q > -GATE_LIMIT && q < GATE_LIMIT) q = 0;
					r.processed_sample = q[15:0];
					mag = (q < 0) ? -q : q;
					if (mag > 32767) mag = 32767;
					if (mag > peak_acc) peak_acc = mag[14:0];
					sq_sum += 41'(longint'(q) * longint'(q));
					n_samples++;
					if (it.last_in_chunk || n_samples >= MAX_CHUNK) begin
						rms = isqrt(64'(sq_sum) / 64'(n_samples));
						r.chunk_done = 1;
						r.rms_val = rms[15:0];
						r.peak_mag = peak_acc;
						if (ring_pos >= LEVEL_HISTORY) ring_pos = 0;
						ring_sum = ring_sum - 20'(ring[ring_pos]) + 20'(rms);
						ring[ring_pos] = rms[15:0];
						ring_pos = (ring_pos + 1 >= LEVEL_HISTORY) ? 0 : ring_pos + 1;
						det = (rms > thresh) &&
							(64'(rms) * (2 * LEVEL_HISTORY) > 64'(ring_sum) * 3);
						if (det && !voice) begin
							start_seg(r);
						end else if (!det && voice) begin
							hang_cnt = hang_ticks;
							hang_run = 1;
						end
						sq_sum = 0; n_samples = 0; peak_acc = 0;
					end
				end
				OP_TICK: begin
					now_ms++;
					if (hang_run) begin
						if (hang_cnt <= 1) begin
							hang_cnt = 0;
							hang_run = 0;
							if (voice) end_seg(r);
						end else begin
							hang_cnt--;
						end
					end
				end
				OP_START: if (!voice) start_seg(r);
				OP_END:   if (voice) end_seg(r);
			endcase
			r.voice_on = voice;
			r.segment_count = seg_cnt;
			r.duration_ms = voice ? now_ms - voice_at : now_ms - quiet_at;
			pending.push_back(r);
		endfunction

		function void check_result(result_t got);
			result_t e;
			if (pending.size() == 0) begin
				$error("result with nothing expected");
				errors++;
				return;
			end
			e = pending.pop_front();
			if (got.processed_sample !== e.processed_sample) begin
				$error("processed_sample exp %0d got %0d", e.processed_sample,
					got.processed_sample);
				errors++;
			end
			if (got.chunk_done !== e.chunk_done) begin
				$error("chunk_done exp %0d got %0d", e.chunk_done, got.chunk_done);
				errors++;
			end
			if (got.rms_val !== e.rms_val) begin
				$error("rms_val exp %0d got %0d", e.rms_val, got.rms_val);
				errors++;
			end
			if (got.peak_mag !== e.peak_mag) begin
				$error("peak_mag exp %0d got %0d", e.peak_mag, got.peak_mag);
				errors++;
			end
			if (got.voice_on !== e.voice_on) begin
				$error("voice_on exp %0d got %0d", e.voice_on, got.voice_on);
				errors++;
			end
			if (got.event_code !== e.event_code) begin
				$error("event_code exp %0d got %0d", e.event_code, got.event_code);
				errors++;
			end
			if (got.segment_count !== e.segment_count) begin
				$error("segment_count exp %0d got %0d", e.segment_count,
					got.segment_count);
				errors++;
			end
			if (got.duration_ms !== e.duration_ms) begin
				$error("duration_ms exp %0d got %0d", e.duration_ms, got.duration_ms);
				errors++;
			end
		endfunction
	endclass

	logic        clk, arst_n;
	logic        item_valid, item_ready, result_valid, result_ready;
	item_t       item;
	result_t     result;
	logic        psel, penable, pwrite, pready;
	logic [3:0]  paddr;
	logic [31:0] pwdata, prdata;

	vad_scoreboard sb;
	bit          calm;        // no random idling
	int          hold_off;    // receiver stall request, in cycles
	longint      cycles;

	audio_gain_gate_vad dut (.*);

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	// Abort on a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 2_000_000) begin
			$display("audio_gain_gate_vad_tb NOT OK");
			$finish;
		end
	end

	// Drain results with random and long stalls
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ready <= 0;
		end else begin
			if (result_valid && result_ready) sb.check_result(result);
			if (hold_off > 0) begin
				hold_off <= hold_off - 1;
				result_ready <= 0;
			end else begin
				result_ready <= calm || ($urandom_range(99) >= 6);
			end
		end
	end

	task automatic write_reg(reg_idx_t idx, logic [31:0] v);
		psel <= 1; penable <= 0; pwrite <= 1; paddr <= 4'(idx) << 2; pwdata <= v;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
		sb.set_reg(idx, v);
	endtask

	// Offer one request and hold it until accepted
	task automatic send(op_t op, logic signed [15:0] s, logic last);
		while (!calm && $urandom_range(99) < 6) begin
			item_valid <= 0;
			@(posedge clk);
		end
		item_valid <= 1;
		item <= '{operation: op, sample_in: s, last_in_chunk: last};
		do @(posedge clk); while (!item_ready);
		sb.note_request('{operation: op, sample_in: s, last_in_chunk: last});
	endtask

	// Wait for all results, then let a trailing chunk finish
	task automatic drain();
		item_valid <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	task automatic rand_sample(logic last);
		logic signed [15:0] s;
		case ($urandom_range(3))
			0: s = 16'($urandom);
			1: s = 16'($urandom_range(600) - 300);
			default: s = 16'(($urandom_range(1) ? 1 : -1) * int'($urandom_range(20000, 2000)));
		endcase
		send(OP_SAMPLE, s, last);
	endtask

	// Mostly chunks of samples with ticks; a few forces
	task automatic random_phase(int n);
		int k, len;
		k = 0;
		while (k < n) begin
			case ($urandom_range(9))
				0: begin send(OP_START, 16'($urandom), 1'($urandom)); k++; end
				1: begin send(OP_END, 16'($urandom), 1'($urandom)); k++; end
				2, 3: begin
					repeat ($urandom_range(8, 1)) begin
						send(OP_TICK, 16'($urandom), 1'($urandom)); k++;
					end
				end
				default: begin
					len = $urandom_range(12, 1);
					for (int i = 0; i < len; i++) begin
						rand_sample(i == len - 1);
						k++;
					end
				end
			endcase
		end
	endtask

	initial begin
		sb = new();
		calm = 0; hold_off = 0; cycles = 0;
		arst_n = 0; item_valid = 0; item = '0;
		psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: extremes, all operations, gating, forced start and end
		send(OP_SAMPLE, 16'sh7FFF, 1'b0);
		send(OP_SAMPLE, -16'sd32768, 1'b0);
		send(OP_SAMPLE, 16'sd0, 1'b1);
		send(OP_TICK, 16'sd0, 1'b0);
		send(OP_START, 16'sd0, 1'b0);
		send(OP_START, 16'sd0, 1'b0);
		send(OP_TICK, 16'sd0, 1'b0);
		send(OP_END, 16'sd0, 1'b0);
		send(OP_END, 16'sd0, 1'b0);
		drain();
		write_reg(REG_GAIN, 32'd512);
		write_reg(REG_GATE, 32'd1);
		write_reg(REG_THRESHOLD, 32'd0);
		write_reg(REG_HANGOVER, 32'd0);
		send(OP_SAMPLE, -16'sd32768, 1'b0);
		send(OP_SAMPLE, 16'sd163, 1'b0);
		send(OP_SAMPLE, -16'sd164, 1'b1);
		send(OP_SAMPLE, 16'sd20000, 1'b1);
		send(OP_SAMPLE, 16'sd1, 1'b1);
		send(OP_TICK, 16'sd0, 1'b0);
		send(OP_TICK, 16'sd0, 1'b0);
		drain();
		write_reg(REG_GAIN, 32'd1023);
		send(OP_SAMPLE, 16'sh7FFF, 1'b1);
		send(OP_SAMPLE, -16'sd1, 1'b1);
		drain();
		write_reg(REG_GAIN, 32'd0);
		write_reg(REG_THRESHOLD, 32'h0000_FFFF);
		write_reg(REG_HANGOVER, 32'h0000_FFFF);
		send(OP_SAMPLE, 16'sh7FFF, 1'b1);
		drain();

		// Overlong chunk ends at the maximum length, sent with no idling
		write_reg(REG_GAIN, 32'd128);
		write_reg(REG_GATE, 32'd0);
		write_reg(REG_THRESHOLD, 32'd655);
		calm = 1;
		for (int i = 0; i < MAX_CHUNK; i++) send(OP_SAMPLE, 16'($urandom), 1'b0);
		drain();

		// Random phases over several settings, one with the receiver held off
		write_reg(REG_HANGOVER, 32'd3);
		write_reg(REG_THRESHOLD, 32'd300);
		random_phase(30);
		calm = 0;
		hold_off = 300;
		random_phase(40);
		drain();
		write_reg(REG_GAIN, 32'd384);
		write_reg(REG_GATE, 32'd1);
		write_reg(REG_HANGOVER, 32'd1);
		random_phase(30);
		drain();
		write_reg(REG_GAIN, 32'd256);
		write_reg(REG_GATE, 32'd0);
		write_reg(REG_THRESHOLD, 32'd32768);
		write_reg(REG_HANGOVER, 32'd20);
		random_phase(30);
		drain();

		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("audio_gain_gate_vad_tb OK");
		else
			$display("audio_gain_gate_vad_tb NOT OK");
		$finish;
	end
endmodule

// ----- sim.f -----
sv/agv_pkg.sv
sv/agv_ctrl.sv
sv/agv_dp.sv
sv/audio_gain_gate_vad.sv
test/audio_gain_gate_vad_tb.sv
